>>> rtl/wto_pkg.sv
// Package for the wavetable oscillator voices: sizes, codes and item structs.
// Used by the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package wto_pkg;
	localparam int VOICES     = 16;
	localparam int TABLE_LEN  = 2048;
	localparam int LEVELS     = 8;
	localparam int ROW_LEN    = TABLE_LEN + 1;
	localparam int MEM_DEPTH  = 2 * LEVELS * ROW_LEN;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int TIDX_W     = $clog2(TABLE_LEN);
	localparam int LVL_W      = 3;

	localparam logic [2:0] CMD_SAMPLE = 3'd0;
	localparam logic [2:0] CMD_SETINC = 3'd1;
	localparam logic [2:0] CMD_WORD   = 3'd2;
	localparam logic [2:0] CMD_LIMIT  = 3'd3;
	localparam logic [2:0] CMD_GAIN   = 3'd4;
	localparam logic [2:0] CMD_RSTPH  = 3'd5;

	localparam logic [1:0] REG_MIX   = 2'd0;
	localparam logic [1:0] REG_PULSE = 2'd1;
	localparam logic [1:0] REG_BCNT  = 2'd2;
	localparam logic [1:0] REG_SCNT  = 2'd3;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [3:0]         voice;
		logic [31:0]        increment;
		logic               group;
		logic [2:0]         level;
		logic [11:0]        position;
		logic signed [15:0] table_word;
		logic [15:0]        gain;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic [3:0]         voice_out;
	} out_item_t;

	// row base of a (group, level) pair in table memory
	function automatic logic [ADDR_W-1:0] row_base(input logic grp, input logic [2:0] lvl);
		logic [ADDR_W-1:0] r;
		r = ADDR_W'({grp, lvl});
		return ADDR_W'(r * ADDR_W'(ROW_LEN));
	endfunction
endpackage
`default_nettype wire

>>> rtl/wavetable_oscillator_voices.sv
// Top level of the wavetable oscillator voices; sequencer around the shared unit.
// Depends on wto_pkg, wto_ram, wto_mac.
`timescale 1ns / 1ps
`default_nettype none
// Sixteen-voice mipmapped wavetable oscillator. Table loads, limit loads, gain,
// phase reset and set increment on voices other than 0 finish as they are
// accepted; set increment on voice 0 then scans the level limits of both groups.
// A sample item interpolates between two table words, adds a crossfade read when
// the mix is nonzero and a second pass at the pulse offset when that is set, and
// its result waits for out_ready while that is low. The time an item takes is
// set by the single table RAM port (two words per interpolation, one read at a
// time) and the shared multiply unit which does every interpolation, crossfade
// and gain step in turn. in_ready is low while an item is in work or a result
// waits in the output register. Table memory, limits and gains are undefined
// until written.
module wavetable_oscillator_voices (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire wto_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output wto_pkg::out_item_t     out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);
	localparam logic [3:0] S_IDLE = 4'd0, S_LIM = 4'd1, S_RD0 = 4'd2, S_RD1 = 4'd3,
		S_RD2 = 4'd4, S_INT = 4'd5, S_INTW = 4'd6, S_MIX = 4'd7, S_MIXW = 4'd8,
		S_AVG = 4'd9, S_GAIN = 4'd10, S_GAINW = 4'd11, S_OUT = 4'd12, S_LIMW = 4'd13;

	logic [3:0]  state_q;
	logic [15:0] mix_q;
	logic [31:0] pulse_q;
	logic [3:0]  bcnt_q, scnt_q;
	logic [2:0]  bsel_q, ssel_q;
	logic [31:0] phase_q [wto_pkg::VOICES];
	logic [31:0] inc_q   [wto_pkg::VOICES];
	logic [15:0] gain_q  [wto_pkg::VOICES];
	logic [31:0] lim_q   [2*wto_pkg::LEVELS];

	logic [3:0]  voice_q;
	logic [31:0] rph_q;       // phase for current read
	logic [1:0]  rd_q;        // 0 base plain, 1 second, 2 base offset, 3 second again
	logic signed [17:0] s0_q, s1_q, a_q, b_q, acc_q;
	logic        grp_q;
	logic [2:0]  sel_q;
	logic [31:0] sinc_q;
	logic [3:0]  ncnt_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q <= '0; pulse_q <= '0; bcnt_q <= 4'd1; scnt_q <= 4'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wto_pkg::REG_MIX:   mix_q   <= cfg_data[15:0];
				wto_pkg::REG_PULSE: pulse_q <= cfg_data;
				wto_pkg::REG_BCNT:  bcnt_q  <= cfg_data[3:0];
				wto_pkg::REG_SCNT:  scnt_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// table RAM
	logic                       ram_we;
	logic [wto_pkg::ADDR_W-1:0] ram_addr;
	logic [15:0]                ram_rd;
	logic [wto_pkg::ADDR_W-1:0] rd_base, rd_addr;
	logic [43:0] prod;
	logic [10:0] tidx;
	logic [15:0] frac;
	logic        rd_sec;
	always_comb begin
		rd_sec  = rd_q[0];
		prod    = 44'(rph_q) * 44'(wto_pkg::TABLE_LEN);
		tidx    = prod[42:32];
		frac    = prod[31:16];
		rd_base = wto_pkg::row_base(rd_sec, rd_sec ? ssel_q : bsel_q);
		rd_addr = rd_base + wto_pkg::ADDR_W'(tidx);
		ram_we  = in_valid && in_ready && in_data.cmd == wto_pkg::CMD_WORD
			&& in_data.position <= 12'(wto_pkg::TABLE_LEN);
		if (state_q == S_IDLE)
			ram_addr = wto_pkg::row_base(in_data.group, in_data.level)
				+ wto_pkg::ADDR_W'(in_data.position);
		else if (state_q == S_RD0)
			ram_addr = rd_addr;
		else
			ram_addr = rd_addr + wto_pkg::ADDR_W'(1);
	end
	wto_ram #(.WIDTH(16), .DEPTH(wto_pkg::MEM_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_data.table_word), .rdata(ram_rd));

	// shared unit operands; gain operands are held in S_GAIN and S_GAINW so the
	// result register still carries the gain product in S_OUT
	logic signed [17:0] ma, mb, mr;
	logic        [16:0] mm;
	logic               msh;
	always_comb begin
		ma = s0_q; mb = s1_q; mm = {1'b0, frac}; msh = 1'b0;
		if (state_q == S_MIX) begin
			ma = a_q; mb = acc_q; mm = {1'b0, mix_q};
		end else if (state_q == S_GAIN || state_q == S_GAINW) begin
			ma = '0; mb = acc_q; mm = {1'b0, gain_q[voice_q]}; msh = 1'b1;
		end
	end
	wto_mac u_mac (.clk(clk), .a(ma), .b(mb), .m(mm), .sh15(msh), .r(mr));

	logic signed [17:0] sat;
	always_comb begin
		sat = mr;
		if (mr > 18'sd32767) sat = 18'sd32767;
		else if (mr < -18'sd32768) sat = -18'sd32768;
	end

	logic [3:0] ncl;
	logic [31:0] np;
	always_comb begin
		ncl = (ncnt_q == 4'd0) ? 4'd1
			: (ncnt_q > 4'(wto_pkg::LEVELS) ? 4'(wto_pkg::LEVELS) : ncnt_q);
		np  = phase_q[in_data.voice] + inc_q[in_data.voice];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_valid <= 1'b0; bsel_q <= '0; ssel_q <= '0;
			for (int i = 0; i < wto_pkg::VOICES; i++) begin
				phase_q[i] <= '0; inc_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					voice_q <= in_data.voice;
					case (in_data.cmd)
						wto_pkg::CMD_SAMPLE: begin
							phase_q[in_data.voice] <= np;
							rph_q <= np; rd_q <= 2'd0; state_q <= S_RD0;
						end
						wto_pkg::CMD_SETINC: begin
							inc_q[in_data.voice] <= in_data.increment;
							if (in_data.voice == 4'd0) begin
								sinc_q <= in_data.increment; grp_q <= 1'b1;
								ncnt_q <= scnt_q; sel_q <= '0; state_q <= S_LIM;
							end
						end
						wto_pkg::CMD_LIMIT:
							lim_q[{in_data.group, in_data.level}] <= in_data.increment;
						wto_pkg::CMD_GAIN: gain_q[in_data.voice] <= in_data.gain;
						wto_pkg::CMD_RSTPH:
							for (int i = 0; i < wto_pkg::VOICES; i++) phase_q[i] <= '0;
						default: ;
					endcase
				end
				S_LIM: begin
					if (4'(sel_q) + 4'd1 < ncl && sinc_q >= lim_q[{grp_q, sel_q}])
						sel_q <= sel_q + 3'd1;
					else begin
						if (grp_q) ssel_q <= sel_q; else bsel_q <= sel_q;
						state_q <= S_LIMW;
					end
				end
				S_LIMW: if (grp_q) begin
					grp_q <= 1'b0; ncnt_q <= bcnt_q; sel_q <= '0; state_q <= S_LIM;
				end else state_q <= S_IDLE;
				S_RD0: state_q <= S_RD1;
				S_RD1: begin s0_q <= 18'($signed(ram_rd)); state_q <= S_RD2; end
				S_RD2: begin s1_q <= 18'($signed(ram_rd)); state_q <= S_INT; end
				S_INT: state_q <= S_INTW;
				S_INTW: begin
					// mr = interpolated read rd_q
					if (rd_q[0]) begin
						acc_q <= mr; state_q <= S_MIX;
					end else begin
						a_q <= mr;
						if (mix_q == 16'd0) begin acc_q <= mr; state_q <= S_AVG; end
						else begin rd_q <= rd_q | 2'd1; state_q <= S_RD0; end
					end
				end
				S_MIX: state_q <= S_MIXW;
				S_MIXW: begin acc_q <= mr; a_q <= mr; state_q <= S_AVG; end
				S_AVG: begin
					// acc_q and a_q both hold the mixed value of this pass
					if (pulse_q != 32'd0 && !rd_q[1]) begin
						b_q <= acc_q; rd_q <= 2'd2;
						rph_q <= phase_q[voice_q] + pulse_q; state_q <= S_RD0;
					end else begin
						if (pulse_q != 32'd0) begin
							a_q <= b_q;
							acc_q <= (b_q + acc_q) >>> 1;
						end
						state_q <= S_GAIN;
					end
				end
				S_GAIN: state_q <= S_GAINW;
				S_GAINW: state_q <= S_OUT;
				S_OUT: begin
					out_data.sample <= sat[15:0]; out_data.voice_out <= voice_q;
					out_valid <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// second read uses plain phase
			if (state_q == S_INTW && !rd_q[0] && mix_q != 16'd0) rph_q <= phase_q[voice_q];
		end
	end
endmodule
`default_nettype wire

>>> rtl/wto_ram.sv
// Generic single port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wto_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> rtl/wto_mac.sv
// Shared arithmetic unit: r = a + floor(m * (b - a) / 2^sh), registered.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wto_mac (
	input  wire logic               clk,
	input  wire logic signed [17:0] a,
	input  wire logic signed [17:0] b,
	input  wire logic        [16:0] m,
	input  wire logic               sh15,
	output logic signed      [17:0] r
);
	logic signed [18:0] d;
	logic signed [36:0] p;
	logic signed [36:0] q;
	always_comb begin
		d = 19'(b) - 19'(a);
		p = 37'(d) * $signed({20'd0, m});
		q = sh15 ? (p >>> 15) : (p >>> 16);
	end
	always_ff @(posedge clk) r <= 18'(37'(a) + q);
endmodule
`default_nettype wire

>>> rtl/wto_checker.sv
// Port checker for the wavetable oscillator voices, bound to the top level.
// Depends on wto_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wto_port_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire wto_pkg::out_item_t out_data
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready with result pending");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready || !out_valid) else $error("busy");
endmodule
bind wavetable_oscillator_voices wto_port_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .out_data(out_data));
`default_nettype wire
